/* src/adplc_pkg.sv */
// Package for the analog point deadband and limit check block.
// Holds the codes, configuration and queue entry types shared by the modules that import it.
// No dependencies.
`default_nettype none

package adplc_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 25;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN         = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OFFSET       = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEADBAND_PCT = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_JUMP_LIMIT   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOW_WARN     = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOW_ALARM    = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HIGH_WARN    = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HIGH_ALARM   = 3'd7;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_ERROR  = 1'b1;

   localparam logic EVENT_SAMPLE = 1'b0;
   localparam logic EVENT_ERROR  = 1'b1;

   localparam logic signed [1:0] DIR_NONE = 2'sd0;
   localparam logic signed [1:0] DIR_UP   = 2'sd1;
   localparam logic signed [1:0] DIR_DOWN = -2'sd1;

   localparam logic signed [2:0] LEVEL_LOW_ALARM  = -3'sd2;
   localparam logic signed [2:0] LEVEL_LOW_WARN   = -3'sd1;
   localparam logic signed [2:0] LEVEL_OK         = 3'sd0;
   localparam logic signed [2:0] LEVEL_HIGH_WARN  = 3'sd1;
   localparam logic signed [2:0] LEVEL_HIGH_ALARM = 3'sd2;

   localparam logic [7:0] ERROR_RESET = 8'd255;
   localparam logic [7:0] ERROR_CLEAR = 8'd0;

   localparam logic signed [15:0] GAIN_RESET  = 16'sd256;
   localparam logic signed [24:0] SCALED_MAX  = 25'sd16777215;
   localparam logic signed [24:0] SCALED_MIN  = -25'sd16777216;

   typedef struct packed {
      logic signed [15:0] gain;
      logic signed [23:0] offset;
      logic [6:0]         deadband_pct;
      logic [6:0]         jump_limit;
      logic signed [24:0] low_warn;
      logic signed [24:0] low_alarm;
      logic signed [24:0] high_warn;
      logic signed [24:0] high_alarm;
   } cfg_type;

   typedef struct packed {
      logic               event_kind;
      logic [7:0]         raw_value;
      logic signed [1:0]  jump_direction;
      logic signed [8:0]  signed_jump;
      logic [7:0]         jump_size;
      logic [7:0]         error_out;
   } mid_entry_type;

   typedef struct packed {
      logic               event_kind;
      logic signed [24:0] scaled_value;
      logic [7:0]         raw_value;
      logic signed [1:0]  jump_direction;
      logic signed [8:0]  signed_jump;
      logic [7:0]         jump_size;
      logic signed [2:0]  limit_level;
      logic [7:0]         error_out;
   } rsp_entry_type;

endpackage

`default_nettype wire

/* src/adplc_fifo.sv */
// Small synchronous queue built from registers, used between the stages.
// Standalone; carries any packed payload as a flat vector.
`default_nettype none

module adplc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire logic [WIDTH-1:0]           push_data,
   output logic                            full,
   input  wire logic                       pop,
   output logic [WIDTH-1:0]                pop_data,
   output logic                            empty,
   output logic [$clog2(DEPTH+1)-1:0]      count
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

/* src/adplc_front.sv */
// Front end: accepts items, applies the deadband and change filters and the jump check.
// Holds the last sample and error code state. Depends on adplc_pkg.
`default_nettype none

module adplc_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire adplc_pkg::cfg_type    cfg,
   input  wire logic                  item_valid,
   input  wire logic                  item_kind,
   input  wire logic [7:0]            item_raw,
   input  wire logic [7:0]            item_error,
   input  wire logic                  mid_full,
   output logic                       item_ready,
   output logic                       mid_push,
   output adplc_pkg::mid_entry_type   mid_entry
);

   import adplc_pkg::*;

   logic [7:0] last_raw_ff, last_raw_in;
   logic [7:0] error_code_ff, error_code_in;
   logic       accept;
   logic       is_error;
   logic       rising;
   logic [7:0] delta;
   logic [9:0] five_pct;
   logic [9:0] twice_delta;
   logic       in_deadband;
   logic       emit;
   logic       jump_on;
   logic       jump_hit;

   assign item_ready = !mid_full;
   assign accept     = item_valid && item_ready;
   assign is_error   = (item_kind == KIND_ERROR);
   assign rising     = (item_raw > last_raw_ff);
   assign delta      = rising ? (item_raw - last_raw_ff) : (last_raw_ff - item_raw);

   // The threshold floor(250 * pct / 100) exceeds delta exactly when 5 * pct >= 2 * delta + 2.
   assign five_pct    = {1'b0, cfg.deadband_pct, 2'b00} + {3'b000, cfg.deadband_pct};
   assign twice_delta = {1'b0, delta, 1'b0} + 10'd2;
   assign in_deadband = (cfg.deadband_pct != '0) && (five_pct >= twice_delta);

   assign emit = is_error ? (item_error != error_code_ff)
                          : ((item_raw != last_raw_ff) && !in_deadband);
   assign mid_push = accept && emit;

   assign jump_on  = (cfg.jump_limit != '0);
   assign jump_hit = jump_on && (delta > {1'b0, cfg.jump_limit});

   always_comb begin
      mid_entry                = '0;
      mid_entry.raw_value      = last_raw_ff;
      mid_entry.jump_direction = DIR_NONE;
      if (is_error) begin
         mid_entry.event_kind = EVENT_ERROR;
         mid_entry.error_out  = item_error;
      end else begin
         mid_entry.event_kind = EVENT_SAMPLE;
         mid_entry.raw_value  = item_raw;
         mid_entry.error_out  = ERROR_CLEAR;
         mid_entry.jump_size  = jump_on ? delta : 8'd0;
         if (jump_hit) begin
            mid_entry.jump_direction = rising ? DIR_UP : DIR_DOWN;
            mid_entry.signed_jump    = rising ? $signed({1'b0, delta})
                                              : -$signed({1'b0, delta});
         end
      end
   end

   always_comb begin
      last_raw_in   = last_raw_ff;
      error_code_in = error_code_ff;
      if (accept) begin
         if (is_error) begin
            error_code_in = item_error;
         end else if (emit) begin
            last_raw_in   = item_raw;
            error_code_in = ERROR_CLEAR;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff   <= '0;
         error_code_ff <= ERROR_RESET;
      end else begin
         last_raw_ff   <= last_raw_in;
         error_code_ff <= error_code_in;
      end
   end

endmodule

`default_nettype wire

/* src/adplc_back.sv */
// Back end: scales samples with the gain and offset and classifies them against the limits.
// Multiply in the first stage, add and compare in the second. Depends on adplc_pkg.
`default_nettype none

module adplc_back #(
   parameter int DEPTH = adplc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire adplc_pkg::cfg_type            cfg,
   input  wire logic                          mid_empty,
   input  wire adplc_pkg::mid_entry_type      mid_entry,
   output logic                               mid_pop,
   input  wire logic [$clog2(DEPTH+1)-1:0]    out_count,
   output logic                               out_push,
   output adplc_pkg::rsp_entry_type           out_entry
);

   import adplc_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   logic               stage_valid_ff, stage_valid_in;
   mid_entry_type      stage_entry_ff;
   logic signed [24:0] product_ff;
   logic signed [24:0] scaled;
   logic [CW:0]        pending;
   logic signed [2:0]  level;

   // An output slot is reserved for the beat held in the multiply stage.
   assign pending        = {1'b0, out_count} + {{CW{1'b0}}, stage_valid_ff};
   assign mid_pop        = !mid_empty && (pending < (CW + 1)'(DEPTH));
   assign stage_valid_in = mid_pop;
   assign out_push       = stage_valid_ff;

   // The product stays within 24 signed bits, so the sum cannot leave the 25-bit range.
   assign scaled = product_ff + {{1{cfg.offset[23]}}, cfg.offset};

   always_comb begin
      level = LEVEL_OK;
      if (scaled < cfg.low_warn) begin
         level = (scaled < cfg.low_alarm) ? LEVEL_LOW_ALARM : LEVEL_LOW_WARN;
      end else if (scaled > cfg.high_warn) begin
         level = (scaled > cfg.high_alarm) ? LEVEL_HIGH_ALARM : LEVEL_HIGH_WARN;
      end
   end

   always_comb begin
      out_entry                = '0;
      out_entry.event_kind     = stage_entry_ff.event_kind;
      out_entry.raw_value      = stage_entry_ff.raw_value;
      out_entry.error_out      = stage_entry_ff.error_out;
      out_entry.jump_direction = stage_entry_ff.jump_direction;
      out_entry.signed_jump    = stage_entry_ff.signed_jump;
      out_entry.jump_size      = stage_entry_ff.jump_size;
      if (stage_entry_ff.event_kind == EVENT_SAMPLE) begin
         out_entry.scaled_value = scaled;
         out_entry.limit_level  = level;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_pop) begin
         stage_entry_ff <= mid_entry;
         product_ff     <= $signed({1'b0, mid_entry.raw_value}) * cfg.gain;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

endmodule

`default_nettype wire

/* src/analog_point_deadband_limit_check.sv */
// Analog point check: one item per cycle is accepted while the front queue is not full.
// An item that makes an event sends it through the queue, the multiply stage and the
// output queue; it then shows on the result ports and can be popped.
// The multiply stage and the output queue use a slot reservation, so the rate
// stays one beat per cycle while the consumer keeps popping.
// Synchronous active-high reset empties both queues, sets the last sample to 0,
// the error code to 255 and all configuration registers to their defaults.
`default_nettype none

module analog_point_deadband_limit_check #(
   parameter int QUEUE_DEPTH = adplc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_push,
   output logic                                         req_full,
   input  wire logic                                    req_kind,
   input  wire logic [7:0]                              req_raw_sample,
   input  wire logic [7:0]                              req_error_in,
   output logic                                         rsp_empty,
   input  wire logic                                    rsp_pop,
   output logic                                         rsp_event_kind,
   output logic signed [24:0]                           rsp_scaled_value,
   output logic [7:0]                                   rsp_raw_value,
   output logic signed [1:0]                            rsp_jump_direction,
   output logic signed [8:0]                            rsp_signed_jump,
   output logic [7:0]                                   rsp_jump_size,
   output logic signed [2:0]                            rsp_limit_level,
   output logic [7:0]                                   rsp_error_out,
   input  wire logic                                    csr_valid,
   output logic                                         csr_ready,
   input  wire logic [adplc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [adplc_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);

   import adplc_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cfg_type        cfg_ff, cfg_in;
   logic           front_ready;
   logic           mid_push, mid_full, mid_pop, mid_empty;
   mid_entry_type  mid_push_entry, mid_pop_entry;
   logic           out_push;
   rsp_entry_type  out_push_entry, out_pop_entry;
   logic [CW-1:0]  out_count;

   assign csr_ready = 1'b1;
   assign req_full  = !front_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_GAIN:         cfg_in.gain         = csr_data[15:0];
            CSR_OFFSET:       cfg_in.offset       = csr_data[23:0];
            CSR_DEADBAND_PCT: cfg_in.deadband_pct = csr_data[6:0];
            CSR_JUMP_LIMIT:   cfg_in.jump_limit   = csr_data[6:0];
            CSR_LOW_WARN:     cfg_in.low_warn     = csr_data;
            CSR_LOW_ALARM:    cfg_in.low_alarm    = csr_data;
            CSR_HIGH_WARN:    cfg_in.high_warn    = csr_data;
            CSR_HIGH_ALARM:   cfg_in.high_alarm   = csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain         <= GAIN_RESET;
         cfg_ff.offset       <= '0;
         cfg_ff.deadband_pct <= '0;
         cfg_ff.jump_limit   <= '0;
         cfg_ff.low_warn     <= SCALED_MIN;
         cfg_ff.low_alarm    <= SCALED_MIN;
         cfg_ff.high_warn    <= SCALED_MAX;
         cfg_ff.high_alarm   <= SCALED_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   adplc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (req_push),
      .item_kind  (req_kind),
      .item_raw   (req_raw_sample),
      .item_error (req_error_in),
      .mid_full   (mid_full),
      .item_ready (front_ready),
      .mid_push   (mid_push),
      .mid_entry  (mid_push_entry)
   );

   adplc_fifo #(
      .WIDTH ($bits(mid_entry_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_push_entry),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_pop_entry),
      .empty     (mid_empty),
      .count     ()
   );

   adplc_back #(
      .DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .mid_empty (mid_empty),
      .mid_entry (mid_pop_entry),
      .mid_pop   (mid_pop),
      .out_count (out_count),
      .out_push  (out_push),
      .out_entry (out_push_entry)
   );

   adplc_fifo #(
      .WIDTH ($bits(rsp_entry_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_push_entry),
      .full      (),
      .pop       (rsp_pop),
      .pop_data  (out_pop_entry),
      .empty     (rsp_empty),
      .count     (out_count)
   );

   assign rsp_event_kind     = out_pop_entry.event_kind;
   assign rsp_scaled_value   = out_pop_entry.scaled_value;
   assign rsp_raw_value      = out_pop_entry.raw_value;
   assign rsp_jump_direction = out_pop_entry.jump_direction;
   assign rsp_signed_jump    = out_pop_entry.signed_jump;
   assign rsp_jump_size      = out_pop_entry.jump_size;
   assign rsp_limit_level    = out_pop_entry.limit_level;
   assign rsp_error_out      = out_pop_entry.error_out;

endmodule

`default_nettype wire

/* test/adplc_point_checker.sv */
// Checker for the analog point deadband and limit check block.
// Watches the request, result and register channels, predicts each event and
// compares it field by field. Depends on adplc_pkg.
`timescale 1ns / 1ps

module adplc_point_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   input  logic                                  req_full,
   input  logic                                  req_kind,
   input  logic [7:0]                            req_raw_sample,
   input  logic [7:0]                            req_error_in,
   input  logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   input  logic                                  rsp_event_kind,
   input  logic signed [24:0]                    rsp_scaled_value,
   input  logic [7:0]                            rsp_raw_value,
   input  logic signed [1:0]                     rsp_jump_direction,
   input  logic signed [8:0]                     rsp_signed_jump,
   input  logic [7:0]                            rsp_jump_size,
   input  logic signed [2:0]                     rsp_limit_level,
   input  logic [7:0]                            rsp_error_out,
   input  logic                                  csr_valid,
   input  logic                                  csr_ready,
   input  logic [adplc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [adplc_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   output int                                    fail_count,
   output int                                    pending_count,
   output int                                    compared_count
);

   import adplc_pkg::*;

   localparam int DEADBAND_SPAN = 250;
   localparam int PERCENT_FULL  = 100;

   cfg_type       point_cfg;
   logic [7:0]    last_sample;
   logic [7:0]    held_error;
   rsp_entry_type expected_events[$];
   int            failures = 0;
   int            pending = 0;
   int            compared = 0;

   assign fail_count     = failures;
   assign pending_count  = pending;
   assign compared_count = compared;

   function automatic cfg_type reset_setting();
      cfg_type s;
      s.gain         = GAIN_RESET;
      s.offset       = '0;
      s.deadband_pct = '0;
      s.jump_limit   = '0;
      s.low_warn     = SCALED_MIN;
      s.low_alarm    = SCALED_MIN;
      s.high_warn    = SCALED_MAX;
      s.high_alarm   = SCALED_MAX;
      return s;
   endfunction

   task automatic write_setting(input logic [CSR_INDEX_WIDTH-1:0] index,
                                input logic [CSR_DATA_WIDTH-1:0] data);
      case (index)
         CSR_GAIN:         point_cfg.gain         = data[15:0];
         CSR_OFFSET:       point_cfg.offset       = data[23:0];
         CSR_DEADBAND_PCT: point_cfg.deadband_pct = data[6:0];
         CSR_JUMP_LIMIT:   point_cfg.jump_limit   = data[6:0];
         CSR_LOW_WARN:     point_cfg.low_warn     = data;
         CSR_LOW_ALARM:    point_cfg.low_alarm    = data;
         CSR_HIGH_WARN:    point_cfg.high_warn    = data;
         CSR_HIGH_ALARM:   point_cfg.high_alarm   = data;
         default: ;
      endcase
   endtask

   // Returns 1 when the item produces an event, with the event in ev.
   function automatic bit predict_point_event(input logic kind, input logic [7:0] raw,
                                              input logic [7:0] err,
                                              output rsp_entry_type ev);
      int     delta;
      int     threshold;
      longint scaled;
      ev = '0;
      if (kind == KIND_ERROR) begin
         if (err == held_error) return 1'b0;
         held_error    = err;
         ev.event_kind = EVENT_ERROR;
         ev.raw_value  = last_sample;
         ev.error_out  = err;
         return 1'b1;
      end
      if (raw == last_sample) return 1'b0;
      delta = (raw > last_sample) ? int'(raw) - int'(last_sample)
                                  : int'(last_sample) - int'(raw);
      threshold = DEADBAND_SPAN * int'(point_cfg.deadband_pct) / PERCENT_FULL;
      if (point_cfg.deadband_pct != 0 && threshold > delta) return 1'b0;

      scaled = longint'(raw) * longint'(point_cfg.gain) + longint'(point_cfg.offset);
      if (scaled > longint'(SCALED_MAX)) scaled = longint'(SCALED_MAX);
      if (scaled < longint'(SCALED_MIN)) scaled = longint'(SCALED_MIN);

      ev.event_kind     = EVENT_SAMPLE;
      ev.scaled_value   = scaled[24:0];
      ev.raw_value      = raw;
      ev.jump_direction = DIR_NONE;
      if (point_cfg.jump_limit != 0) begin
         ev.jump_size = delta[7:0];
         if (delta > int'(point_cfg.jump_limit)) begin
            if (raw > last_sample) begin
               ev.jump_direction = DIR_UP;
               ev.signed_jump    = 9'(delta);
            end else begin
               ev.jump_direction = DIR_DOWN;
               ev.signed_jump    = 9'(-delta);
            end
         end
      end

      ev.limit_level = LEVEL_OK;
      if (scaled < longint'(point_cfg.low_warn)) begin
         ev.limit_level = (scaled < longint'(point_cfg.low_alarm)) ? LEVEL_LOW_ALARM
                                                                   : LEVEL_LOW_WARN;
      end else if (scaled > longint'(point_cfg.high_warn)) begin
         ev.limit_level = (scaled > longint'(point_cfg.high_alarm)) ? LEVEL_HIGH_ALARM
                                                                    : LEVEL_HIGH_WARN;
      end

      last_sample  = raw;
      held_error   = ERROR_CLEAR;
      ev.error_out = ERROR_CLEAR;
      return 1'b1;
   endfunction

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_entry_type predicted;
      rsp_entry_type oldest;
      bit            emits;
      if (reset) begin
         point_cfg   = reset_setting();
         last_sample = '0;
         held_error  = ERROR_RESET;
         expected_events.delete();
      end else begin
         if (csr_valid && csr_ready) write_setting(csr_index, csr_data);
         if (req_push && !req_full) begin
            emits = predict_point_event(req_kind, req_raw_sample, req_error_in, predicted);
            if (emits) expected_events.push_back(predicted);
         end
         if (rsp_pop && !rsp_empty) begin
            if (expected_events.size() == 0) begin
               $display("%0t: event with nothing expected, event_kind %0d raw_value %0d",
                        $time, rsp_event_kind, rsp_raw_value);
               failures++;
            end else begin
               oldest = expected_events.pop_front();
               check_field("event_kind", oldest.event_kind, rsp_event_kind);
               check_field("scaled_value", oldest.scaled_value, rsp_scaled_value);
               check_field("raw_value", oldest.raw_value, rsp_raw_value);
               check_field("jump_direction", oldest.jump_direction, rsp_jump_direction);
               check_field("signed_jump", oldest.signed_jump, rsp_signed_jump);
               check_field("jump_size", oldest.jump_size, rsp_jump_size);
               check_field("limit_level", oldest.limit_level, rsp_limit_level);
               check_field("error_out", oldest.error_out, rsp_error_out);
               compared++;
            end
         end
      end
      pending = expected_events.size();
   end

endmodule

/* test/tb_analog_point_deadband_limit_check.sv */
// Top of the analog point deadband and limit check testbench.
// Drives readings, error reports and register settings into the block and
// gives the verdict; depends on adplc_pkg, the block and adplc_point_checker.
`timescale 1ns / 1ps

module tb_analog_point_deadband_limit_check;
   import adplc_pkg::*;

   localparam int CLOCK_PERIOD      = 20;
   localparam int RESET_CYCLES      = 8;
   localparam int QUIET_CYCLES      = 8;
   localparam int RANDOM_SETTINGS   = 12;
   localparam int ITEMS_PER_SETTING = 110;
   localparam int TIMEOUT_CYCLES    = 400000;
   localparam int DEADBAND_SPAN     = 250;
   localparam int PERCENT_FULL      = 100;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_push = 1'b0;
   logic                       req_full;
   logic                       req_kind = KIND_SAMPLE;
   logic [7:0]                 req_raw_sample = '0;
   logic [7:0]                 req_error_in = '0;
   logic                       rsp_empty;
   logic                       rsp_pop = 1'b0;
   logic                       rsp_event_kind;
   logic signed [24:0]         rsp_scaled_value;
   logic [7:0]                 rsp_raw_value;
   logic signed [1:0]          rsp_jump_direction;
   logic signed [8:0]          rsp_signed_jump;
   logic [7:0]                 rsp_jump_size;
   logic signed [2:0]          rsp_limit_level;
   logic [7:0]                 rsp_error_out;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data = '0;
   int                         fail_count;
   int                         pending_count;
   int                         compared_count;

   cfg_type    active;
   logic [7:0] last_raw_sent = '0;
   logic [7:0] last_err_sent = ERROR_RESET;
   int         burst_left = 0;
   bit         steady = 1'b0;
   int         readings_sent = 0;
   int         writes_done = 0;
   int         settings_done = 0;
   int         pop_mode = 0;
   int         pop_span = 0;
   logic [1:0] pop_tick = '0;

   analog_point_deadband_limit_check DUT (.*);

   adplc_point_checker point_check (.*);

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(negedge clock) begin
      if (pop_span == 0) begin
         pop_mode <= $urandom_range(0, 3);
         pop_span <= $urandom_range(20, 120);
      end else begin
         pop_span <= pop_span - 1;
      end
      case (pop_mode)
         0: rsp_pop <= 1'b1;
         1: rsp_pop <= 1'($urandom_range(0, 1));
         2: rsp_pop <= (pop_tick == 2'b00);
         default: rsp_pop <= ($urandom_range(0, 7) == 0);
      endcase
      pop_tick <= pop_tick + 2'd1;
   end

   function automatic cfg_type default_setting();
      cfg_type s;
      s.gain         = GAIN_RESET;
      s.offset       = '0;
      s.deadband_pct = '0;
      s.jump_limit   = '0;
      s.low_warn     = SCALED_MIN;
      s.low_alarm    = SCALED_MIN;
      s.high_warn    = SCALED_MAX;
      s.high_alarm   = SCALED_MAX;
      return s;
   endfunction

   function automatic cfg_type random_setting();
      cfg_type s;
      longint  lo;
      longint  hi;
      longint  swap;
      longint  marks[$];
      s = default_setting();
      case ($urandom_range(0, 9))
         0: s.gain = 16'sh7FFF;
         1: s.gain = 16'sh8000;
         2: s.gain = '0;
         3: s.gain = GAIN_RESET;
         default: s.gain = 16'($urandom);
      endcase
      case ($urandom_range(0, 7))
         0: s.offset = 24'h7FFFFF;
         1: s.offset = 24'h800000;
         2: s.offset = '0;
         default: s.offset = 24'($urandom);
      endcase
      case ($urandom_range(0, 9))
         0, 1, 2, 3: s.deadband_pct = '0;
         4: s.deadband_pct = 7'd100;
         5: s.deadband_pct = 7'($urandom_range(101, 127));
         default: s.deadband_pct = 7'($urandom_range(1, 40));
      endcase
      case ($urandom_range(0, 7))
         0, 1: s.jump_limit = '0;
         2: s.jump_limit = 7'd127;
         3: s.jump_limit = 7'd1;
         default: s.jump_limit = 7'($urandom_range(1, 126));
      endcase
      lo = longint'(s.offset);
      hi = lo + 255 * longint'(s.gain);
      if (hi < lo) begin
         swap = lo;
         lo   = hi;
         hi   = swap;
      end
      case ($urandom_range(0, 9))
         0: ;
         1: begin
            s.low_warn   = 25'($urandom);
            s.low_alarm  = 25'($urandom);
            s.high_warn  = 25'($urandom);
            s.high_alarm = 25'($urandom);
         end
         2: begin
            s.low_warn   = 25'(hi);
            s.low_alarm  = 25'(lo + (hi - lo) / 2);
            s.high_warn  = 25'(lo);
            s.high_alarm = 25'(lo + (hi - lo) / 2);
         end
         default: begin
            repeat (4) marks.push_back(lo - 64 + longint'($urandom_range(0, 32'(hi - lo + 128))));
            marks.sort();
            s.low_alarm  = 25'(marks[0]);
            s.low_warn   = 25'(marks[1]);
            s.high_warn  = 25'(marks[2]);
            s.high_alarm = 25'(marks[3]);
         end
      endcase
      return s;
   endfunction

   task automatic send_reading(input logic kind, input logic [7:0] raw, input logic [7:0] err);
      if (burst_left == 0) begin
         if (!steady) begin
            req_push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_kind       <= kind;
      req_raw_sample <= raw;
      req_error_in   <= err;
      req_push       <= 1'b1;
      do @(posedge clock); while (req_full);
      @(negedge clock);
      readings_sent++;
   endtask

   task automatic send_random_reading();
      int         choice;
      int         band;
      int         level;
      logic [7:0] raw;
      logic [7:0] err;
      choice = $urandom_range(0, 99);
      raw    = 8'($urandom);
      err    = 8'($urandom);
      if (choice < 22) begin
         case ($urandom_range(0, 5))
            0, 1: err = last_err_sent;
            2: err = ERROR_CLEAR;
            3: err = ERROR_RESET;
            default: ;
         endcase
         last_err_sent = err;
         send_reading(KIND_ERROR, raw, err);
      end else begin
         if (choice < 45) begin
            band  = DEADBAND_SPAN * int'(active.deadband_pct) / PERCENT_FULL;
            band  = (band > 252) ? 255 : band + 3;
            level = $urandom_range(0, band);
            level = ($urandom_range(0, 1) == 1) ? int'(last_raw_sent) + level
                                                : int'(last_raw_sent) - level;
            if (level < 0) level = 0;
            if (level > 255) level = 255;
            raw = 8'(level);
         end else if (choice < 53) begin
            raw = last_raw_sent;
         end else if (choice < 60) begin
            raw = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
         end
         last_raw_sent = raw;
         send_reading(KIND_SAMPLE, raw, err);
      end
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic [CSR_DATA_WIDTH-1:0] data);
      csr_index <= index;
      csr_data  <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      writes_done++;
   endtask

   task automatic load_setting(input cfg_type s);
      write_register(CSR_GAIN, {{9{s.gain[15]}}, s.gain});
      write_register(CSR_OFFSET, {s.offset[23], s.offset});
      write_register(CSR_DEADBAND_PCT, {18'b0, s.deadband_pct});
      write_register(CSR_JUMP_LIMIT, {18'b0, s.jump_limit});
      write_register(CSR_LOW_WARN, s.low_warn);
      write_register(CSR_LOW_ALARM, s.low_alarm);
      write_register(CSR_HIGH_WARN, s.high_warn);
      write_register(CSR_HIGH_ALARM, s.high_alarm);
      csr_valid <= 1'b0;
      active = s;
      settings_done++;
   endtask

   task automatic wait_quiet();
      req_push <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   initial begin
      cfg_type s;
      active = default_setting();
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_reading(KIND_ERROR, 8'h00, ERROR_RESET);
      send_reading(KIND_ERROR, 8'hFF, 8'd7);
      send_reading(KIND_ERROR, 8'h00, 8'd7);
      send_reading(KIND_SAMPLE, 8'h00, 8'h00);
      send_reading(KIND_SAMPLE, 8'hFF, 8'h00);
      send_reading(KIND_SAMPLE, 8'hFF, 8'hFF);
      send_reading(KIND_ERROR, 8'h55, ERROR_CLEAR);
      send_reading(KIND_ERROR, 8'hAA, ERROR_RESET);
      send_reading(KIND_SAMPLE, 8'h00, 8'hFF);
      wait_quiet();

      s            = default_setting();
      s.gain       = 16'sh7FFF;
      s.offset     = 24'h7FFFFF;
      s.deadband_pct = 7'd100;
      s.jump_limit = 7'd127;
      s.low_alarm  = -25'sd2000;
      s.low_warn   = -25'sd1000;
      s.high_warn  = 25'sd1000;
      s.high_alarm = 25'sd12000000;
      load_setting(s);
      send_reading(KIND_SAMPLE, 8'hFF, 8'h00);
      send_reading(KIND_SAMPLE, 8'h00, 8'h00);
      send_reading(KIND_SAMPLE, 8'd200, 8'h00);
      send_reading(KIND_ERROR, 8'h00, 8'h80);
      wait_quiet();

      s            = default_setting();
      s.gain       = 16'sh8000;
      s.offset     = 24'h800000;
      s.jump_limit = 7'd1;
      s.low_warn   = -25'sd8388608;
      s.low_alarm  = -25'sd12000000;
      load_setting(s);
      send_reading(KIND_SAMPLE, 8'hFF, 8'h00);
      send_reading(KIND_SAMPLE, 8'hFE, 8'h00);
      send_reading(KIND_SAMPLE, 8'd100, 8'h00);
      send_reading(KIND_SAMPLE, 8'h00, 8'h00);
      send_reading(KIND_ERROR, 8'h00, 8'h01);
      wait_quiet();

      s              = default_setting();
      s.deadband_pct = 7'd127;
      load_setting(s);
      send_reading(KIND_SAMPLE, 8'hFF, 8'h00);
      send_reading(KIND_ERROR, 8'h00, 8'h01);
      send_reading(KIND_ERROR, 8'h00, 8'h02);
      wait_quiet();

      for (int p = 0; p < RANDOM_SETTINGS; p++) begin
         load_setting(random_setting());
         steady = ($urandom_range(0, 3) == 0);
         repeat (ITEMS_PER_SETTING) send_random_reading();
         wait_quiet();
      end

      $display("Run covered %0d readings and error reports under %0d register settings",
               readings_sent, settings_done);
      $display("(%0d register writes); %0d events were compared.", writes_done, compared_count);
      if (fail_count == 0) begin
         $display("tb_analog_point_deadband_limit_check: done, clean");
      end else begin
         $display("tb_analog_point_deadband_limit_check: done, errors");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("Timed out with %0d events still expected.", pending_count);
      $display("tb_analog_point_deadband_limit_check: done, errors");
      $finish;
   end

endmodule
